@@ src/lbp3_pkg.sv @@
`default_nettype none

package lbp3_pkg;

  typedef logic [7:0] pix_t;

  // per-item control carried alongside the line store read
  typedef struct packed {
    logic emit;
    logic last;
    logic left;
    logic right;
    logic up;
    logic down;
  } ctl_t;

  typedef struct packed {
    logic last;
    pix_t code;
  } res_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [12:0] WIDTH_RESET  = 13'd4096;
  localparam logic [12:0] HEIGHT_RESET = 13'd4096;

  localparam pix_t WT_LEFT        = 8'd128;
  localparam pix_t WT_LOWER_LEFT  = 8'd64;
  localparam pix_t WT_BELOW       = 8'd32;
  localparam pix_t WT_LOWER_RIGHT = 8'd16;
  localparam pix_t WT_RIGHT       = 8'd8;
  localparam pix_t WT_UPPER_RIGHT = 8'd4;
  localparam pix_t WT_ABOVE       = 8'd2;
  localparam pix_t WT_UPPER_LEFT  = 8'd1;

endpackage

`default_nettype wire

@@ src/lbp3_line_store.sv @@
`default_nettype none

module lbp3_line_store #(
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  input  wire logic [$clog2(DEPTH)-1:0] req_addr,
  input  wire lbp3_pkg::pix_t           req_pix,
  output logic                          rsp_valid,
  output lbp3_pkg::pix_t                rsp_top,
  output lbp3_pkg::pix_t                rsp_mid,
  output lbp3_pkg::pix_t                rsp_new
);
  import lbp3_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // {upper row, middle row} per column
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_data;
  logic [15:0]   cur;
  logic [15:0]   wr_data;
  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  pix_t          s1_pix;
  logic          fwd_hit;
  logic [15:0]   fwd_data;

  // write of the item ahead lands in the cycle this one was read
  assign cur       = fwd_hit ? fwd_data : rd_data;
  assign wr_data   = {cur[7:0], s1_pix};
  assign rsp_valid = s1_valid;
  assign rsp_top   = cur[15:8];
  assign rsp_mid   = cur[7:0];
  assign rsp_new   = s1_pix;

  always_ff @(posedge clk) begin
    if (req_valid) begin
      rd_data <= mem[req_addr];
    end
    if (s1_valid) begin
      mem[s1_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= req_valid;
      fwd_hit  <= req_valid && s1_valid && (s1_addr == req_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      s1_addr  <= req_addr;
      s1_pix   <= req_pix;
      fwd_data <= wr_data;
    end
  end

`ifndef ASSERT_OFF
  a_fwd_needs_writer: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1_valid)
    else $error("forward hit without an item in the write stage");
`endif

endmodule

`default_nettype wire

@@ src/lbp3_window.sv @@
`default_nettype none

module lbp3_window (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           clear,
  input  wire logic           in_valid,
  input  wire lbp3_pkg::pix_t top_pix,
  input  wire lbp3_pkg::pix_t mid_pix,
  input  wire lbp3_pkg::pix_t new_pix,
  input  wire lbp3_pkg::ctl_t ctl,
  output logic                res_valid,
  output lbp3_pkg::res_t      res
);
  import lbp3_pkg::*;

  // [row: top, mid, bottom][col: left, mid, right]
  pix_t win [3][3];
  pix_t nxt [3][3];
  pix_t centre;
  pix_t code;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nxt[r][0] = win[r][1];
      nxt[r][1] = win[r][2];
    end
    nxt[0][2] = top_pix;
    nxt[1][2] = mid_pix;
    nxt[2][2] = new_pix;
  end

  always_comb begin
    centre = nxt[1][1];
    code   = '0;
    if (ctl.left && nxt[1][0] > centre) code = code | WT_LEFT;
    if (ctl.down && ctl.left && nxt[2][0] > centre) code = code | WT_LOWER_LEFT;
    if (ctl.down && nxt[2][1] > centre) code = code | WT_BELOW;
    if (ctl.down && ctl.right && nxt[2][2] > centre) code = code | WT_LOWER_RIGHT;
    if (ctl.right && nxt[1][2] > centre) code = code | WT_RIGHT;
    if (ctl.up && ctl.right && nxt[0][2] > centre) code = code | WT_UPPER_RIGHT;
    if (ctl.up && nxt[0][1] > centre) code = code | WT_ABOVE;
    if (ctl.up && ctl.left && nxt[0][0] > centre) code = code | WT_UPPER_LEFT;
  end

  assign res_valid = in_valid && ctl.emit;
  assign res.code  = code;
  assign res.last  = ctl.last;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (in_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= (ctl.emit && ctl.last) ? '0 : nxt[r][c];
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/lbp3_out_buf.sv @@
`default_nettype none

module lbp3_out_buf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lbp3_pkg::res_t din,
  output logic                m_valid,
  input  wire logic           m_ready,
  output lbp3_pkg::res_t      dout,
  output logic [1:0]          count
);
  import lbp3_pkg::*;

  localparam logic [1:0] LAST_SLOT = 2'd2;
  localparam logic [1:0] FULL      = 2'd3;

  res_t       slots [3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       pop;

  assign m_valid = (count != 2'd0);
  assign pop     = m_valid && m_ready;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? 2'd0 : rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != FULL))
    else $error("result pushed into a full output buffer");
`endif

endmodule

`default_nettype wire

@@ src/lbp_3x3_image_filter_top.sv @@
// 3x3 local binary pattern filter over a raster stream of 8-bit pixels.
// Input channel s_axis: one item per pixel (tuser 0) or a flush item (tuser 1).
// Output channel m_axis: one LBP code per pixel in raster order, tlast on the
// final pixel of the frame. Frame size is set over the APB port: width at
// byte address 0, height at 4; a write restarts the frame.
// The code of a pixel comes with the item width + 1 positions later, so at
// the end of a frame width + 1 flush items drive out what is pending; a flush
// sent while pixels are still expected is dropped.
// An accepted item's result goes through the registered line store read, then
// the window update and compare, which push it into the output buffer.
// Throughput: one item per cycle while s_axis_tready is high. The line store
// is one read-modify-write memory, read in the accept cycle and written the
// next; a same-column back-to-back access (one-pixel rows) is forwarded.
// A three-entry output buffer decouples the sides: s_axis_tready drops only
// when it and the item in flight would fill it, so a stalled receiver holds
// results without loss and no more results get in than its entries can hold.
// Reset (synchronous, rst high) empties the pipeline, restarts the frame and
// sets width and height to 4096. Line store contents are not cleared.
`default_nettype none

module lbp_3x3_image_filter_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  wire logic        s_axis_tuser,   // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] lbp_code
  output logic             m_axis_tlast
);
  import lbp3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);

  logic [12:0]   width_reg;
  logic [12:0]   height_reg;
  logic          cfg_we;
  reg_idx_t      cfg_idx;
  int            w_int;
  int            h_int;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [AW-1:0] in_col;
  logic [RW-1:0] in_row;
  logic [AW-1:0] out_col;
  logic [HW-1:0] out_row;

  logic          in_fire;
  logic          pixels_done;
  logic          ignore;
  logic          go;
  pix_t          in_val;
  logic          emit;
  logic [WW-1:0] col_inc;
  logic          col_wrap;
  logic [WW-1:0] oc_inc;
  logic [HW-1:0] or_inc;
  ctl_t          ctl;
  ctl_t          s1_ctl;

  logic          rsp_valid;
  pix_t          rsp_top;
  pix_t          rsp_mid;
  pix_t          rsp_new;
  logic          res_valid;
  res_t          res;
  res_t          out_res;
  logic [1:0]    occ;
  logic          s1_emit;

  // configuration
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_reg  <= pwdata[12:0];
        REG_HEIGHT: height_reg <= pwdata[12:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = {19'd0, width_reg};
      REG_HEIGHT: prdata = {19'd0, height_reg};
      default:    prdata = '0;
    endcase
  end

  // zero counts as one, oversize as the maximum
  always_comb begin
    w_int = (width_reg == '0) ? 1 :
            ((int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    h_int = (height_reg == '0) ? 1 :
            ((int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
    w_eff = WW'(w_int);
    h_eff = HW'(h_int);
  end

  // input side
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign pixels_done = (in_row >= RW'(h_eff));
  assign ignore      = in_fire && (s_axis_tuser == KIND_FLUSH) && !pixels_done;
  assign go          = in_fire && !ignore;
  assign in_val      = pixels_done ? '0 : s_axis_tdata;
  assign emit        = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_col != '0));
  assign col_inc     = WW'(in_col) + WW'(1);
  assign col_wrap    = (col_inc >= w_eff);
  assign oc_inc      = WW'(out_col) + WW'(1);
  assign or_inc      = out_row + HW'(1);

  always_comb begin
    ctl.emit  = emit;
    ctl.left  = (out_col != '0);
    ctl.right = (oc_inc < w_eff);
    ctl.up    = (out_row != '0);
    ctl.down  = (or_inc < h_eff);
    ctl.last  = !ctl.right && !ctl.down;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (go) begin
      if (emit && ctl.last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col <= col_wrap ? '0 : in_col + AW'(1);
        if (col_wrap) begin
          in_row <= in_row + RW'(1);
        end
        if (emit) begin
          out_col <= ctl.right ? out_col + AW'(1) : '0;
          if (!ctl.right) begin
            out_row <= or_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_ctl <= ctl;
    end
  end

  assign s1_emit       = rsp_valid && s1_ctl.emit;
  assign s_axis_tready = (({1'b0, occ}) + {2'b00, s1_emit}) <= 3'd2;

  lbp3_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk       (clk),
    .rst       (rst),
    .req_valid (go),
    .req_addr  (in_col),
    .req_pix   (in_val),
    .rsp_valid (rsp_valid),
    .rsp_top   (rsp_top),
    .rsp_mid   (rsp_mid),
    .rsp_new   (rsp_new)
  );

  lbp3_window u_window (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .in_valid  (rsp_valid),
    .top_pix   (rsp_top),
    .mid_pix   (rsp_mid),
    .new_pix   (rsp_new),
    .ctl       (s1_ctl),
    .res_valid (res_valid),
    .res       (res)
  );

  lbp3_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (res_valid),
    .din     (res),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .dout    (out_res),
    .count   (occ)
  );

  assign m_axis_tdata = out_res.code;
  assign m_axis_tlast = out_res.last;

`ifndef ASSERT_OFF
  a_go_reaches_store: assert property (@(posedge clk) disable iff (rst)
    go |=> rsp_valid)
    else $error("accepted item did not reach the line store stage");

  a_flush_dropped: assert property (@(posedge clk) disable iff (rst)
    (ignore && !cfg_we) |=> ($stable(in_col) && $stable(in_row)))
    else $error("early flush item moved the input position");

  a_room_for_result: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, occ}) + {2'b00, s1_emit}) <= 3'd3)
    else $error("results in flight exceed output buffer room");
`endif

endmodule

`default_nettype wire
